// File: sv/mwm_pkg.sv
// Shared widths, reset values, register indexes and types for the mecanum wheel mixer.
package mwm_pkg;

	localparam int CHAN_W       = 11;
	localparam int LIMIT_W      = 15;
	localparam int OFF_W        = CHAN_W + 1;
	localparam int SCALE_W      = 18;
	localparam int PROD_W       = 30;
	localparam int WHEEL_W      = 31;
	localparam int MAG_W        = 30;
	localparam int OUT_W        = 16;
	localparam int QUO_W        = LIMIT_W;
	localparam int NUM_W        = MAG_W + LIMIT_W;
	localparam int NUM_WHEELS   = 4;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = LIMIT_W;
	localparam int DIV_CNT_W    = $clog2(QUO_W + 1);

	localparam int WHEEL_FL     = 0;
	localparam int WHEEL_FR     = 1;
	localparam int WHEEL_RL     = 2;
	localparam int WHEEL_RR     = 3;

	localparam int LIMIT_RESET  = 8000;
	localparam int MIN_RESET    = 364;
	localparam int MAX_RESET    = 1684;
	localparam int SCALE_FACTOR = 2;
	localparam int SCALE_RESET  = SCALE_FACTOR * (LIMIT_RESET / (MAX_RESET - MIN_RESET));

	localparam int QUEUE_DEPTH  = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPEED_LIMIT = 2'd0,
		CFG_STICK_MIN   = 2'd1,
		CFG_STICK_MAX   = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [LIMIT_W-1:0]        speed_limit;
		logic [CHAN_W-1:0]         stick_min;
		logic signed [SCALE_W-1:0] scale;
		logic                      busy;
	} cfg_view_t;

	typedef struct packed {
		logic [NUM_WHEELS-1:0][WHEEL_W-1:0] wheel;
		logic [MAG_W-1:0]                   top;
		logic                               over;
	} mix_entry_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL,
		BK_DIV,
		BK_DONE
	} back_state_t;

endpackage

// File: sv/mwm_cfg.sv
// Configuration registers and the serial divider that derives the channel scale.
module mwm_cfg import mwm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_view_t             cfg
);

	logic [LIMIT_W-1:0]        limit_q;
	logic [CHAN_W-1:0]         min_q;
	logic [CHAN_W-1:0]         max_q;
	logic signed [SCALE_W-1:0] scale_q;
	logic                      busy_q;
	logic                      init_q;
	logic [DIV_CNT_W-1:0]      cnt_q;
	logic [CHAN_W-1:0]         rem_q;
	logic [QUO_W-1:0]          quo_q;
	logic [CHAN_W-1:0]         dvs_q;
	logic                      neg_q;
	logic                      zero_q;

	logic                      wr;
	logic signed [OFF_W-1:0]   span;
	logic [OFF_W-1:0]          span_abs;
	logic [CHAN_W:0]           trial;
	logic [CHAN_W:0]           diff;
	logic                      ge;
	logic signed [SCALE_W-1:0] scale_mag;
	logic signed [SCALE_W-1:0] scale_next;

	assign cfg_ready = !busy_q;
	assign wr        = cfg_valid && cfg_ready;

	always_comb begin
		span       = $signed({1'b0, max_q}) - $signed({1'b0, min_q});
		span_abs   = span[OFF_W-1] ? OFF_W'(-span) : OFF_W'(span);
		trial      = {rem_q, quo_q[QUO_W-1]};
		ge         = trial >= {1'b0, dvs_q};
		diff       = trial - {1'b0, dvs_q};
		scale_mag  = $signed(SCALE_W'({quo_q, 1'b0}));
		scale_next = zero_q ? '0 : (neg_q ? -scale_mag : scale_mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_W'(LIMIT_RESET);
			min_q   <= CHAN_W'(MIN_RESET);
			max_q   <= CHAN_W'(MAX_RESET);
			scale_q <= SCALE_W'(SCALE_RESET);
			busy_q  <= 1'b0;
			init_q  <= 1'b0;
			cnt_q   <= '0;
		end else if (wr) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SPEED_LIMIT: limit_q <= cfg_data;
				CFG_STICK_MIN:   min_q   <= cfg_data[CHAN_W-1:0];
				CFG_STICK_MAX:   max_q   <= cfg_data[CHAN_W-1:0];
				default: ;
			endcase
			busy_q <= 1'b1;
			init_q <= 1'b1;
		end else if (init_q) begin
			init_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(QUO_W);
		end else if (busy_q && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end else if (busy_q) begin
			scale_q <= scale_next;
			busy_q  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (init_q) begin
			dvs_q  <= span_abs[CHAN_W-1:0];
			neg_q  <= span[OFF_W-1];
			zero_q <= span == '0;
			rem_q  <= '0;
			quo_q  <= limit_q;
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= ge ? diff[CHAN_W-1:0] : trial[CHAN_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign cfg.speed_limit = limit_q;
	assign cfg.stick_min   = min_q;
	assign cfg.scale       = scale_q;
	assign cfg.busy        = busy_q;

endmodule

// File: sv/mwm_front.sv
// Front pipeline: accepts stick words, drops incomplete ones, mixes the wheels and finds the peak.
module mwm_front import mwm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CHAN_W-1:0] strafe_channel,
	input  logic [CHAN_W-1:0] forward_channel,
	input  logic [CHAN_W-1:0] spin_channel,
	input  cfg_view_t         cfg,
	input  logic              q_ready,
	output logic              q_push,
	output mix_entry_t        q_data
);

	logic                      en;
	logic                      accept;
	logic                      complete;

	logic                      v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [OFF_W-1:0]   off_x_s1, off_y_s1, off_w_s1;
	logic signed [PROD_W-1:0]  prod_x_s2, prod_y_s2, prod_w_s2;
	logic signed [WHEEL_W-1:0] wheel_s3 [NUM_WHEELS];
	logic signed [WHEEL_W-1:0] wheel_s4 [NUM_WHEELS];
	logic [MAG_W-1:0]          mag_s4 [NUM_WHEELS];
	logic signed [WHEEL_W-1:0] wheel_s5 [NUM_WHEELS];
	logic [MAG_W-1:0]          top_s5;
	logic                      over_s5;

	logic signed [PROD_W-1:0]  scale_ext;
	logic signed [PROD_W-1:0]  ox, oy, ow;
	logic signed [WHEEL_W-1:0] px, py, pw, lim, lim3;
	logic signed [WHEEL_W-1:0] wheel_mix [NUM_WHEELS];
	logic [WHEEL_W-1:0]        abs_full [NUM_WHEELS];
	logic [MAG_W-1:0]          max_a, max_b, top_mix;
	logic                      over_mix;

	assign en       = !(v_s5 && !q_ready);
	assign in_stall = !en || cfg.busy;
	assign accept   = in_valid && !in_stall;
	assign complete = strafe_channel != '0 && forward_channel != '0 && spin_channel != '0;

	always_comb begin
		scale_ext = PROD_W'(cfg.scale);
		ox        = PROD_W'(off_x_s1);
		oy        = PROD_W'(off_y_s1);
		ow        = PROD_W'(off_w_s1);
		px        = WHEEL_W'(prod_x_s2);
		py        = WHEEL_W'(prod_y_s2);
		pw        = WHEEL_W'(prod_w_s2);
		lim       = $signed(WHEEL_W'(cfg.speed_limit));
		lim3      = lim + (lim <<< 1);
		wheel_mix[WHEEL_FL] = px + py + pw - lim3;
		wheel_mix[WHEEL_FR] = -px + py + pw - lim;
		wheel_mix[WHEEL_RL] = px - py + pw - lim;
		wheel_mix[WHEEL_RR] = -px - py + pw + lim;
		over_mix = 1'b0;
		for (int i = 0; i < NUM_WHEELS; i++) begin
			abs_full[i] = wheel_s3[i][WHEEL_W-1] ? WHEEL_W'(-wheel_s3[i]) : WHEEL_W'(wheel_s3[i]);
			over_mix    = over_mix || (mag_s4[i] > MAG_W'(cfg.speed_limit));
		end
		max_a   = (mag_s4[0] > mag_s4[1]) ? mag_s4[0] : mag_s4[1];
		max_b   = (mag_s4[2] > mag_s4[3]) ? mag_s4[2] : mag_s4[3];
		top_mix = (max_a > max_b) ? max_a : max_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept && complete;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			off_x_s1  <= $signed({1'b0, strafe_channel}) - $signed({1'b0, cfg.stick_min});
			off_y_s1  <= $signed({1'b0, forward_channel}) - $signed({1'b0, cfg.stick_min});
			off_w_s1  <= $signed({1'b0, spin_channel}) - $signed({1'b0, cfg.stick_min});
			prod_x_s2 <= ox * scale_ext;
			prod_y_s2 <= oy * scale_ext;
			prod_w_s2 <= ow * scale_ext;
			for (int i = 0; i < NUM_WHEELS; i++) begin
				wheel_s3[i] <= wheel_mix[i];
				wheel_s4[i] <= wheel_s3[i];
				mag_s4[i]   <= abs_full[i][MAG_W-1:0];
				wheel_s5[i] <= wheel_s4[i];
			end
			top_s5  <= top_mix;
			over_s5 <= over_mix;
		end
	end

	assign q_push = v_s5 && q_ready;

	always_comb begin
		for (int i = 0; i < NUM_WHEELS; i++) begin
			q_data.wheel[i] = wheel_s5[i];
		end
		q_data.top  = top_s5;
		q_data.over = over_s5;
	end

endmodule

// File: sv/mwm_queue.sv
// Short queue of mixed wheel sets between the front pipeline and the rescaling back end.
module mwm_queue import mwm_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  mix_entry_t push_data,
	output logic       push_ready,
	input  logic       pop,
	output logic       pop_valid,
	output mix_entry_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mix_entry_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: sv/mwm_back.sv
// Back end: rescales overdriven wheel sets with four serial dividers and holds the output word.
module mwm_back import mwm_pkg::*; (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pop_valid,
	input  mix_entry_t                       pop_data,
	output logic                             pop,
	input  cfg_view_t                        cfg,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [NUM_WHEELS-1:0][OUT_W-1:0] out_wheel
);

	back_state_t               state_q;
	back_state_t               state_d;
	logic signed [WHEEL_W-1:0] wheel_q [NUM_WHEELS];
	logic [MAG_W-1:0]          top_q;
	logic                      over_q;
	logic [MAG_W-1:0]          rem_q [NUM_WHEELS];
	logic [QUO_W-1:0]          lo_q [NUM_WHEELS];
	logic [DIV_CNT_W-1:0]      cnt_q;
	logic                      out_valid_q;
	logic [NUM_WHEELS-1:0][OUT_W-1:0] out_wheel_q;

	logic                      pop_fire;
	logic                      out_load;
	logic [WHEEL_W-1:0]        abs_full [NUM_WHEELS];
	logic [NUM_W-1:0]          prod [NUM_WHEELS];
	logic [MAG_W:0]            trial [NUM_WHEELS];
	logic [MAG_W:0]            diff [NUM_WHEELS];
	logic                      ge [NUM_WHEELS];
	logic [OUT_W-1:0]          quo_ext [NUM_WHEELS];
	logic [OUT_W-1:0]          result [NUM_WHEELS];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (pop_valid) begin
					state_d = pop_data.over ? BK_MUL : BK_DONE;
				end
			end
			BK_MUL: state_d = BK_DIV;
			BK_DIV: begin
				if (cnt_q == DIV_CNT_W'(1)) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (out_load) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop      = state_q == BK_IDLE;
		out_load = state_q == BK_DONE && (!out_valid_q || !out_stall);
	end

	assign pop_fire = pop && pop_valid;

	always_comb begin
		for (int i = 0; i < NUM_WHEELS; i++) begin
			abs_full[i] = wheel_q[i][WHEEL_W-1] ? WHEEL_W'(-wheel_q[i]) : WHEEL_W'(wheel_q[i]);
			prod[i]     = NUM_W'(abs_full[i][MAG_W-1:0]) * NUM_W'(cfg.speed_limit);
			trial[i]    = {rem_q[i], lo_q[i][QUO_W-1]};
			ge[i]       = trial[i] >= {1'b0, top_q};
			diff[i]     = trial[i] - {1'b0, top_q};
			quo_ext[i]  = OUT_W'({1'b0, lo_q[i]});
			if (over_q) begin
				result[i] = wheel_q[i][WHEEL_W-1] ? OUT_W'(-quo_ext[i]) : quo_ext[i];
			end else begin
				result[i] = wheel_q[i][OUT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_MUL) begin
				cnt_q <= DIV_CNT_W'(QUO_W);
			end else if (state_q == BK_DIV) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_fire) begin
			for (int i = 0; i < NUM_WHEELS; i++) begin
				wheel_q[i] <= $signed(pop_data.wheel[i]);
			end
			top_q  <= pop_data.top;
			over_q <= pop_data.over;
		end
		for (int i = 0; i < NUM_WHEELS; i++) begin
			if (state_q == BK_MUL) begin
				rem_q[i] <= prod[i][NUM_W-1:QUO_W];
				lo_q[i]  <= prod[i][QUO_W-1:0];
			end else if (state_q == BK_DIV) begin
				rem_q[i] <= ge[i] ? diff[i][MAG_W-1:0] : trial[i][MAG_W-1:0];
				lo_q[i]  <= {lo_q[i][QUO_W-2:0], ge[i]};
			end
		end
		if (out_load) begin
			for (int i = 0; i < NUM_WHEELS; i++) begin
				out_wheel_q[i] <= result[i];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_wheel = out_wheel_q;

endmodule

// File: sv/mecanum_wheel_mixer.sv
// Top level of the mecanum wheel mixer: stick channels in, four wheel targets out.
//
// Input channel: one word carries the strafe, forward and spin stick values. A word is
// taken at a rising edge with in_valid high and in_stall low. A word with any channel at
// zero is dropped and produces no output word.
// Output channel: one word carries the four wheel targets, held while out_stall is high.
// Configuration channel: cfg_index selects speed_limit, stick_min or stick_max and is
// written when cfg_valid and cfg_ready are both high. Each write starts a 15-step serial
// division for the channel scale; cfg_ready and input acceptance stay low until it ends.
// A set in which any wheel exceeds the speed limit is rescaled; other sets pass unchanged.
// Throughput: the front pipeline takes a word every cycle while in_stall is low. The back end,
// with its four serial dividers, takes the next word only once its output register holds the last.
// A short queue between them absorbs bursts; in_stall rises when it is full and the front holds a finished word.
// Reset loads speed_limit 8000, stick_min 364, stick_max 1684 and the matching scale,
// and empties the pipeline, queue and output register.
// A stalled output holds its word while the back end finishes the next one behind it.
module mecanum_wheel_mixer import mwm_pkg::*; #(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [CHAN_W-1:0]     strafe_channel,
	input  logic [CHAN_W-1:0]     forward_channel,
	input  logic [CHAN_W-1:0]     spin_channel,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [OUT_W-1:0] wheel_front_left,
	output logic signed [OUT_W-1:0] wheel_front_right,
	output logic signed [OUT_W-1:0] wheel_rear_left,
	output logic signed [OUT_W-1:0] wheel_rear_right,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_view_t                        cfg;
	logic                             q_push;
	logic                             q_ready;
	mix_entry_t                       q_in;
	logic                             q_pop;
	logic                             q_valid;
	mix_entry_t                       q_out;
	logic [NUM_WHEELS-1:0][OUT_W-1:0] out_wheel;

	mwm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mwm_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.strafe_channel  (strafe_channel),
		.forward_channel (forward_channel),
		.spin_channel    (spin_channel),
		.cfg             (cfg),
		.q_ready         (q_ready),
		.q_push          (q_push),
		.q_data          (q_in)
	);

	mwm_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_in),
		.push_ready (q_ready),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_data   (q_out)
	);

	mwm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (q_valid),
		.pop_data  (q_out),
		.pop       (q_pop),
		.cfg       (cfg),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_wheel (out_wheel)
	);

	assign wheel_front_left  = $signed(out_wheel[WHEEL_FL]);
	assign wheel_front_right = $signed(out_wheel[WHEEL_FR]);
	assign wheel_rear_left   = $signed(out_wheel[WHEEL_RL]);
	assign wheel_rear_right  = $signed(out_wheel[WHEEL_RR]);

endmodule
